// ===== design/tcce_pkg.sv =====
// Package: request codes, event kinds, configuration indices, state encoding and cell helpers.
`default_nettype none
package tcce_pkg;
  localparam logic [2:0] REQ_PUT      = 3'd0;
  localparam logic [2:0] REQ_PUT_HERE = 3'd1;
  localparam logic [2:0] REQ_SET_CUR  = 3'd2;
  localparam logic [2:0] REQ_CLEAR    = 3'd3;
  localparam logic [2:0] REQ_READ     = 3'd4;

  localparam logic [1:0] EV_WRITE  = 2'd0;
  localparam logic [1:0] EV_SCROLL = 2'd1;
  localparam logic [1:0] EV_CLEAR  = 2'd2;
  localparam logic [1:0] EV_STATUS = 2'd3;

  localparam logic [1:0] CFG_COLS = 2'd0;
  localparam logic [1:0] CFG_ROWS = 2'd1;
  localparam logic [1:0] CFG_FORE = 2'd2;
  localparam logic [1:0] CFG_BACK = 2'd3;

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_PRINT_LO  = 8'h20;
  localparam logic [7:0] CH_PRINT_HI  = 8'h7E;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_DECODE, ST_PUT, ST_EMIT, ST_SCR_RD, ST_SCR_WAIT,
    ST_SCR_WR, ST_BLANK, ST_CLEAR, ST_READ_WAIT, ST_READ_DONE
  } state_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [6:0] cell_row;
    logic [7:0] cell_col;
    logic [7:0] cell_char;
    logic [3:0] cell_fore;
    logic [3:0] cell_back;
    logic [6:0] cursor_row_now;
    logic [7:0] cursor_col_now;
    logic       last;
  } result_t;

  function automatic logic [15:0] make_cell(logic [7:0] ch, logic [3:0] fg,
                                            logic [3:0] bg);
    return {bg, fg, ch};
  endfunction
endpackage
`default_nettype wire

// ===== design/tcce_if.sv =====
// Valid/ready channel interfaces for requests, results and configuration.
`default_nettype none
interface tcce_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] char_code;
  logic [6:0] target_row;
  logic [7:0] target_col;
  modport source (output valid, req_type, char_code, target_row, target_col,
                  input ready);
  modport sink (input valid, req_type, char_code, target_row, target_col,
                output ready);
endinterface

interface tcce_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [6:0] cell_row;
  logic [7:0] cell_col;
  logic [7:0] cell_char;
  logic [3:0] cell_fore;
  logic [3:0] cell_back;
  logic [6:0] cursor_row_now;
  logic [7:0] cursor_col_now;
  logic       last;
  modport source (output valid, event_kind, cell_row, cell_col, cell_char,
                  cell_fore, cell_back, cursor_row_now, cursor_col_now, last,
                  input ready);
  modport sink (input valid, event_kind, cell_row, cell_col, cell_char,
                cell_fore, cell_back, cursor_row_now, cursor_col_now, last,
                output ready);
endinterface

interface tcce_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [8:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/tcce_cell_ram.sv =====
// Single-port-write, single-read cell store with registered read data.
`default_nettype none
module tcce_cell_ram #(
  parameter int AW = 15
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [15:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [15:0]   rdata
);
  logic [15:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/text_console_cell_engine_top.sv =====
// Text console cell engine: request decode, cursor logic and store sequencer.
// Every request ends in a status event; a tab makes up to 8 space writes.
// A new request is taken only when idle with no result pending; the status must be taken first.
// Scroll: each moved cell passes read, wait and write states, then the bottom row is blanked.
// Reset: synchronous; an init pass blanks every cell of the store while requests
// are held off (configuration writes still taken).
`default_nettype none
module text_console_cell_engine_top #(
  parameter int MAX_COLUMNS   = 256,
  parameter int MAX_ROW_COUNT = 128
) (
  input wire logic  clk,
  input wire logic  rst,
  tcce_req_if.sink  req,
  tcce_res_if.source res,
  tcce_cfg_if.sink  cfg
);
  import tcce_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int RW = $clog2(MAX_ROW_COUNT);
  localparam int AW = CW + RW;

  state_t state, state_next;

  logic [8:0] screen_cols;
  logic [7:0] screen_rows;
  logic [3:0] fore_colour, back_colour;
  logic [6:0] cur_row;
  logic [7:0] cur_col;

  logic [2:0] r_type;
  logic [7:0] r_char;
  logic [6:0] t_row;
  logic [7:0] t_col;

  // walk counters for init, scroll and clear
  logic [6:0] w_row;
  logic [7:0] w_col;
  logic [8:0] tab_stop;
  logic       tab_mode;
  logic       pend_scroll;  // scroll follows the queued event
  logic       pend_status;  // status follows the queued event

  logic       out_valid;
  result_t    out_q;

  logic [7:0] cols_m1;
  logic [6:0] rows_m1;
  logic [15:0] blank;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [15:0]     wdata, rdata;

  always_comb begin
    if (screen_cols == 9'd0) cols_m1 = 8'd0;
    else if (screen_cols > 9'(MAX_COLUMNS)) cols_m1 = 8'(MAX_COLUMNS - 1);
    else cols_m1 = 8'(screen_cols - 9'd1);
    if (screen_rows == 8'd0) rows_m1 = 7'd0;
    else if (screen_rows > 8'(MAX_ROW_COUNT)) rows_m1 = 7'(MAX_ROW_COUNT - 1);
    else rows_m1 = 7'(screen_rows - 8'd1);
  end
  assign blank = make_cell(CH_SPACE, fore_colour, back_colour);

  function automatic logic [AW-1:0] addr(logic [6:0] r, logic [7:0] c);
    return {r[RW-1:0], c[CW-1:0]};
  endfunction

  tcce_cell_ram #(.AW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr),
    .rdata(rdata)
  );

  assign req.ready = (state == ST_IDLE) && !out_valid;
  assign cfg.ready = 1'b1;
  assign res.valid = out_valid;
  assign res.event_kind = out_q.event_kind;
  assign res.cell_row = out_q.cell_row;
  assign res.cell_col = out_q.cell_col;
  assign res.cell_char = out_q.cell_char;
  assign res.cell_fore = out_q.cell_fore;
  assign res.cell_back = out_q.cell_back;
  assign res.cursor_row_now = out_q.cursor_row_now;
  assign res.cursor_col_now = out_q.cursor_col_now;
  assign res.last = out_q.last;

  wire out_free = !out_valid || res.ready;
  wire w_col_end = (state == ST_INIT) ? (w_col == 8'(MAX_COLUMNS - 1)) : (w_col == cols_m1);
  wire w_row_end = (state == ST_INIT) ? (w_row == 7'(MAX_ROW_COUNT - 1)) : (w_row == rows_m1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT:     if (w_col_end && w_row_end) state_next = ST_IDLE;
      ST_IDLE:     if (req.valid && req.ready) state_next = ST_DECODE;
      ST_DECODE: begin
        case (r_type)
          REQ_PUT: begin
            if (r_char == CH_NEWLINE)
              state_next = (cur_row >= rows_m1) ? ST_SCR_RD : ST_EMIT;
            else state_next = ST_PUT;
          end
          REQ_PUT_HERE: state_next = ST_PUT;
          REQ_CLEAR:    state_next = ST_CLEAR;
          REQ_READ:     state_next = ST_READ_WAIT;
          default:      state_next = ST_EMIT;
        endcase
      end
      ST_PUT:      if (out_free) state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          if (pend_scroll) state_next = ST_SCR_RD;
          else if (!pend_status) state_next = ST_PUT;
          else state_next = ST_IDLE;
        end
      end
      ST_SCR_RD:   state_next = (rows_m1 == 7'd0) ? ST_BLANK : ST_SCR_WAIT;
      ST_SCR_WAIT: state_next = ST_SCR_WR;
      ST_SCR_WR: begin
        if (w_col_end && (w_row + 7'd1 == rows_m1)) state_next = ST_BLANK;
        else state_next = ST_SCR_RD;
      end
      ST_BLANK:    if (w_col_end) state_next = ST_EMIT;
      ST_CLEAR:    if (w_col_end && w_row_end) state_next = ST_EMIT;
      ST_READ_WAIT: state_next = ST_READ_DONE;
      ST_READ_DONE: if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    we = 1'b0;
    waddr = addr(w_row, w_col);
    wdata = blank;
    raddr = addr(w_row + 7'd1, w_col);
    case (state)
      ST_INIT:  begin we = 1'b1; wdata = make_cell(CH_SPACE, 4'd7, 4'd0); end
      ST_CLEAR: we = 1'b1;
      ST_BLANK: begin we = 1'b1; waddr = addr(rows_m1, w_col); end
      ST_SCR_WR: begin we = 1'b1; wdata = rdata; end
      ST_READ_WAIT: raddr = addr(t_row, t_col);
      ST_PUT: begin
        if (out_free) begin
          waddr = addr(cur_row, cur_col);
          if (r_type == REQ_PUT_HERE) begin
            we = (r_char >= CH_PRINT_LO) && (r_char <= CH_PRINT_HI);
            wdata = make_cell(r_char, fore_colour, back_colour);
          end else if (r_char == CH_BACKSPACE) begin
            we = 1'b1;
            if (cur_col != 8'd0) waddr = addr(cur_row, cur_col - 8'd1);
            else if (cur_row != 7'd0) waddr = addr(cur_row - 7'd1, cols_m1);
          end else if (r_char == CH_RETURN) begin
            we = 1'b0;
          end else begin
            we = !(tab_mode && !({1'b0, cur_col} < tab_stop));
            wdata = make_cell(tab_mode ? CH_SPACE : r_char, fore_colour, back_colour);
          end
        end
      end
      default: ;
    endcase
  end

  function automatic result_t status_item(logic [6:0] cr, logic [7:0] cc);
    result_t s;
    s = '0;
    s.event_kind = EV_STATUS;
    s.last = 1'b1;
    s.cursor_row_now = cr;
    s.cursor_col_now = cc;
    return s;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      screen_cols <= 9'd80;
      screen_rows <= 8'd25;
      fore_colour <= 4'd7;
      back_colour <= 4'd0;
      cur_row <= '0;
      cur_col <= '0;
      w_row <= '0;
      w_col <= '0;
      out_valid <= 1'b0;
      pend_scroll <= 1'b0;
      pend_status <= 1'b0;
      tab_mode <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        case (cfg.index)
          CFG_COLS: screen_cols <= cfg.data;
          CFG_ROWS: screen_rows <= cfg.data[7:0];
          CFG_FORE: fore_colour <= cfg.data[3:0];
          CFG_BACK: back_colour <= cfg.data[3:0];
          default: ;
        endcase
      end
      if (res.ready) out_valid <= 1'b0;
      case (state)
        ST_INIT: begin
          w_col <= w_col_end ? 8'd0 : w_col + 8'd1;
          if (w_col_end) w_row <= w_row + 7'd1;
          if (w_col_end && w_row_end) w_row <= '0;
        end
        ST_IDLE: begin
          if (req.valid && req.ready) begin
            r_type <= req.req_type;
            r_char <= req.char_code;
            t_row <= req.target_row;
            t_col <= req.target_col;
          end
          w_row <= '0;
          w_col <= '0;
          pend_scroll <= 1'b0;
          pend_status <= 1'b0;
        end
        ST_DECODE: begin
          // saturate cursor and targets to the screen in use
          if (cur_row > rows_m1) cur_row <= rows_m1;
          if (cur_col > cols_m1) cur_col <= cols_m1;
          if (t_row > rows_m1) t_row <= rows_m1;
          if (t_col > cols_m1) t_col <= cols_m1;
          tab_mode <= (r_type == REQ_PUT) && (r_char == CH_TAB);
          tab_stop <= ({1'b0, (cur_col > cols_m1) ? cols_m1 : cur_col} + 9'd8) & ~9'd7;
          pend_status <= 1'b1;
          case (r_type)
            REQ_PUT: begin
              if (r_char == CH_NEWLINE) begin
                cur_col <= '0;
                if (cur_row >= rows_m1) begin
                  cur_row <= rows_m1;
                end else cur_row <= cur_row + 7'd1;
              end
            end
            REQ_SET_CUR: begin
              cur_row <= (t_row > rows_m1) ? rows_m1 : t_row;
              cur_col <= (t_col > cols_m1) ? cols_m1 : t_col;
            end
            REQ_CLEAR: begin
              cur_row <= '0;
              cur_col <= '0;
            end
            default: ;
          endcase
        end
        ST_PUT: begin
          if (out_free) begin
            out_valid <= 1'b0;
            out_q <= status_item(cur_row, cur_col);
            if (we) out_valid <= 1'b1;
            out_q.event_kind <= EV_WRITE;
            out_q.last <= 1'b0;
            out_q.cell_row <= cur_row;
            out_q.cell_col <= cur_col;
            out_q.cell_char <= wdata[7:0];
            out_q.cell_fore <= wdata[11:8];
            out_q.cell_back <= wdata[15:12];
            pend_status <= 1'b1;
            if (r_type == REQ_PUT_HERE) begin
              out_q.cursor_row_now <= cur_row;
              out_q.cursor_col_now <= cur_col;
            end else if (r_char == CH_BACKSPACE) begin
              logic [6:0] nr;
              logic [7:0] nc;
              nr = cur_row;
              nc = cur_col;
              if (cur_col != 8'd0) nc = cur_col - 8'd1;
              else if (cur_row != 7'd0) begin nr = cur_row - 7'd1; nc = cols_m1; end
              cur_row <= nr;
              cur_col <= nc;
              out_q.cell_row <= nr;
              out_q.cell_col <= nc;
              out_q.cursor_row_now <= nr;
              out_q.cursor_col_now <= nc;
            end else if (r_char == CH_RETURN) begin
              cur_col <= '0;
            end else if (we) begin
              logic [6:0] nr;
              logic [7:0] nc;
              nr = cur_row;
              nc = cur_col + 8'd1;
              if (cur_col == cols_m1) begin
                nc = '0;
                if (cur_row >= rows_m1) pend_scroll <= 1'b1;
                else nr = cur_row + 7'd1;
              end else if (tab_mode && ({1'b0, nc} < tab_stop)) begin
                pend_status <= 1'b0;  // more tab spaces follow
              end
              cur_row <= nr;
              cur_col <= nc;
              out_q.cursor_row_now <= nr;
              out_q.cursor_col_now <= nc;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (pend_scroll) begin
              out_valid <= 1'b0;
              w_row <= '0;
              w_col <= '0;
            end else if (!pend_status) begin
              out_valid <= 1'b0;
            end else out_q <= status_item(cur_row, cur_col);
          end
        end
        ST_SCR_WR: begin
          w_col <= w_col_end ? 8'd0 : w_col + 8'd1;
          if (w_col_end) w_row <= w_row + 7'd1;
        end
        ST_BLANK: begin
          w_col <= w_col_end ? 8'd0 : w_col + 8'd1;
          if (w_col_end) begin
            // queue scroll event; status follows from ST_EMIT once taken
            pend_scroll <= 1'b0;
            pend_status <= 1'b1;
            out_valid <= 1'b1;
            out_q <= '0;
            out_q.event_kind <= EV_SCROLL;
            out_q.cursor_row_now <= cur_row;
            out_q.cursor_col_now <= cur_col;
          end
        end
        ST_CLEAR: begin
          w_col <= w_col_end ? 8'd0 : w_col + 8'd1;
          if (w_col_end) w_row <= w_row + 7'd1;
          if (w_col_end && w_row_end) begin
            out_valid <= 1'b1;
            out_q <= '0;
            out_q.event_kind <= EV_CLEAR;
          end
        end
        ST_READ_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_q <= status_item(cur_row, cur_col);
            out_q.cell_row <= t_row;
            out_q.cell_col <= t_col;
            out_q.cell_char <= rdata[7:0];
            out_q.cell_fore <= rdata[11:8];
            out_q.cell_back <= rdata[15:12];
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== design/tcce_checker.sv =====
// Port-level checker for the console engine, bound to the top level.
`default_nettype none
module tcce_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       req_valid,
  input wire logic       req_ready,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic [1:0] res_event_kind,
  input wire logic       res_last
);
  import tcce_pkg::*;

  a_last_is_status: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_last |-> res_event_kind == EV_STATUS)
    else $error("last on a non-status item");
  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_event_kind == EV_STATUS |-> res_last)
    else $error("status without last");
  a_no_accept_with_result: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !res_valid)
    else $error("request taken while a result is pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");
endmodule

bind text_console_cell_engine_top tcce_checker u_chk (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .res_valid(res.valid), .res_ready(res.ready),
  .res_event_kind(res.event_kind), .res_last(res.last)
);
`default_nettype wire

// ===== bench/text_console_cell_engine_top_test.sv =====
// Testbench for the text console cell engine: directed and random requests, predicted events.
`timescale 1ns / 1ps
module text_console_cell_engine_top_test;
  import tcce_pkg::*;

  localparam int NCOL = 256;
  localparam int NROW = 128;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #2 clk = ~clk;

  tcce_req_if req ();
  tcce_res_if res ();
  tcce_cfg_if cfg ();

  text_console_cell_engine_top #(.MAX_COLUMNS(NCOL), .MAX_ROW_COUNT(NROW)) dut (
    .clk(clk), .rst(rst), .req(req.sink), .res(res.source), .cfg(cfg.sink)
  );

  // predictor state
  logic [15:0] screen [NROW*NCOL];
  int          cols_reg, rows_reg;
  logic [3:0]  fg_reg, bg_reg;
  int          cur_r, cur_c;
  result_t     pending_events [$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  function automatic int cols_in_use();
    if (cols_reg == 0) return 1;
    if (cols_reg > NCOL) return NCOL;
    return cols_reg;
  endfunction

  function automatic int rows_in_use();
    if (rows_reg == 0) return 1;
    if (rows_reg > NROW) return NROW;
    return rows_reg;
  endfunction

  function automatic void push_event(logic [1:0] kind, int row, int col,
                                     logic [15:0] cell_val, logic lst);
    result_t ev;
    ev.event_kind     = kind;
    ev.cell_row       = row[6:0];
    ev.cell_col       = col[7:0];
    ev.cell_char      = cell_val[7:0];
    ev.cell_fore      = cell_val[11:8];
    ev.cell_back      = cell_val[15:12];
    ev.cursor_row_now = cur_r[6:0];
    ev.cursor_col_now = cur_c[7:0];
    ev.last           = lst;
    pending_events.push_back(ev);
  endfunction

  function automatic void scroll_up();
    int rows, cols;
    rows = rows_in_use();
    cols = cols_in_use();
    for (int r = 0; r + 1 < rows; r++)
      for (int c = 0; c < cols; c++)
        screen[r*NCOL+c] = screen[(r+1)*NCOL+c];
    for (int c = 0; c < cols; c++)
      screen[(rows-1)*NCOL+c] = {bg_reg, fg_reg, CH_SPACE};
    push_event(EV_SCROLL, 0, 0, 16'h0, 1'b0);
  endfunction

  // returns 1 when the put wrapped the line
  function automatic bit store_char(logic [7:0] ch);
    int r, c;
    logic [15:0] cell_val;
    bit wrap_scroll;
    r = cur_r;
    c = cur_c;
    cell_val = {bg_reg, fg_reg, ch};
    wrap_scroll = 0;
    screen[r*NCOL+c] = cell_val;
    cur_c++;
    if (cur_c >= cols_in_use()) begin
      cur_c = 0;
      if (cur_r + 1 >= rows_in_use()) wrap_scroll = 1;
      else cur_r++;
      push_event(EV_WRITE, r, c, cell_val, 1'b0);
      if (wrap_scroll) scroll_up();
      return 1;
    end
    push_event(EV_WRITE, r, c, cell_val, 1'b0);
    return 0;
  endfunction

  function automatic void predict_request(logic [2:0] kind, logic [7:0] ch,
                                          logic [6:0] trow_in, logic [7:0] tcol_in);
    int rows, cols, tr, tc, stop;
    logic [15:0] blank, cell_val;
    rows = rows_in_use();
    cols = cols_in_use();
    blank = {bg_reg, fg_reg, CH_SPACE};
    tr = trow_in;
    tc = tcol_in;
    if (cur_r >= rows) cur_r = rows - 1;
    if (cur_c >= cols) cur_c = cols - 1;
    if (tr >= rows) tr = rows - 1;
    if (tc >= cols) tc = cols - 1;
    case (kind)
      REQ_PUT: begin
        if (ch == CH_NEWLINE) begin
          cur_c = 0;
          if (cur_r + 1 >= rows) scroll_up();
          else cur_r++;
        end else if (ch == CH_RETURN) begin
          cur_c = 0;
        end else if (ch == CH_BACKSPACE) begin
          if (cur_c > 0) cur_c--;
          else if (cur_r > 0) begin
            cur_r--;
            cur_c = cols - 1;
          end
          screen[cur_r*NCOL+cur_c] = blank;
          push_event(EV_WRITE, cur_r, cur_c, blank, 1'b0);
        end else if (ch == CH_TAB) begin
          stop = (cur_c + 8) & ~7;
          while (cur_c < stop && cur_c < cols)
            if (store_char(CH_SPACE)) break;
        end else begin
          void'(store_char(ch));
        end
        push_event(EV_STATUS, 0, 0, 16'h0, 1'b1);
      end
      REQ_PUT_HERE: begin
        if (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) begin
          cell_val = {bg_reg, fg_reg, ch};
          screen[cur_r*NCOL+cur_c] = cell_val;
          push_event(EV_WRITE, cur_r, cur_c, cell_val, 1'b0);
        end
        push_event(EV_STATUS, 0, 0, 16'h0, 1'b1);
      end
      REQ_SET_CUR: begin
        cur_r = tr;
        cur_c = tc;
        push_event(EV_STATUS, 0, 0, 16'h0, 1'b1);
      end
      REQ_CLEAR: begin
        for (int r = 0; r < rows; r++)
          for (int c = 0; c < cols; c++)
            screen[r*NCOL+c] = blank;
        cur_r = 0;
        cur_c = 0;
        push_event(EV_CLEAR, 0, 0, 16'h0, 1'b0);
        push_event(EV_STATUS, 0, 0, 16'h0, 1'b1);
      end
      REQ_READ: push_event(EV_STATUS, tr, tc, screen[tr*NCOL+tc], 1'b1);
      default: push_event(EV_STATUS, 0, 0, 16'h0, 1'b1);
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  task automatic send_request(logic [2:0] kind, logic [7:0] ch,
                              logic [6:0] trow, logic [7:0] tcol);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(posedge clk);
    req.valid      <= 1'b1;
    req.req_type   <= kind;
    req.char_code  <= ch;
    req.target_row <= trow;
    req.target_col <= tcol;
    predict_request(kind, ch, trow, tcol);
    do @(posedge clk); while (!req.ready);
    req.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, int value);
    // registers change only between requests
    while (pending_events.size() != 0) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value[8:0];
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      CFG_COLS: cols_reg = value & 9'h1FF;
      CFG_ROWS: rows_reg = value & 8'hFF;
      CFG_FORE: fg_reg = value[3:0];
      default:  bg_reg = value[3:0];
    endcase
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (pending_events.size() == 0) begin
          report_mismatch("unexpected event kind", res.event_kind, -1);
        end else begin
          want = pending_events.pop_front();
          if (res.event_kind != want.event_kind)
            report_mismatch("event_kind", res.event_kind, want.event_kind);
          if (res.cell_row != want.cell_row)
            report_mismatch("cell_row", res.cell_row, want.cell_row);
          if (res.cell_col != want.cell_col)
            report_mismatch("cell_col", res.cell_col, want.cell_col);
          if (res.cell_char != want.cell_char)
            report_mismatch("cell_char", res.cell_char, want.cell_char);
          if (res.cell_fore != want.cell_fore)
            report_mismatch("cell_fore", res.cell_fore, want.cell_fore);
          if (res.cell_back != want.cell_back)
            report_mismatch("cell_back", res.cell_back, want.cell_back);
          if (res.cursor_row_now != want.cursor_row_now)
            report_mismatch("cursor_row_now", res.cursor_row_now, want.cursor_row_now);
          if (res.cursor_col_now != want.cursor_col_now)
            report_mismatch("cursor_col_now", res.cursor_col_now, want.cursor_col_now);
          if (res.last != want.last)
            report_mismatch("last", res.last, want.last);
        end
      end
      res.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic test_reset_screen();
    // reset contents, then edge of the default screen
    send_request(REQ_READ, 8'h0, 7'd0, 8'd0);
    send_request(REQ_READ, 8'h0, 7'd127, 8'd255);
    send_request(REQ_SET_CUR, 8'h0, 7'd127, 8'd255);
    send_request(REQ_PUT, 8'h41, 7'd0, 8'd0);
    send_request(REQ_READ, 8'h0, 7'd24, 8'd79);
    send_request(3'd5, 8'hFF, 7'h7F, 8'hFF);
    send_request(3'd7, 8'h00, 7'h00, 8'h00);
    wait_drained();
  endtask

  task automatic test_controls();
    send_request(REQ_SET_CUR, 8'h0, 7'd0, 8'd0);
    send_request(REQ_PUT, CH_BACKSPACE, 7'd0, 8'd0);
    send_request(REQ_PUT, 8'h7E, 7'd0, 8'd0);
    send_request(REQ_PUT, CH_TAB, 7'd0, 8'd0);
    send_request(REQ_PUT, CH_RETURN, 7'd0, 8'd0);
    send_request(REQ_PUT, CH_BACKSPACE, 7'd0, 8'd0);
    send_request(REQ_PUT, CH_NEWLINE, 7'd0, 8'd0);
    send_request(REQ_PUT, CH_BACKSPACE, 7'd0, 8'd0);
    send_request(REQ_PUT_HERE, 8'h1F, 7'd0, 8'd0);
    send_request(REQ_PUT_HERE, 8'h7F, 7'd0, 8'd0);
    send_request(REQ_PUT_HERE, 8'h20, 7'd0, 8'd0);
    send_request(REQ_PUT, 8'hFF, 7'd0, 8'd0);
    wait_drained();
  endtask

  task automatic test_small_screen();
    // tiny screen: wraps, scrolls, tab cut at the line end
    write_register(CFG_COLS, 10);
    write_register(CFG_ROWS, 3);
    write_register(CFG_FORE, 15);
    write_register(CFG_BACK, 15);
    send_request(REQ_CLEAR, 8'h0, 7'd0, 8'd0);
    write_register(CFG_FORE, 0);
    write_register(CFG_BACK, 9);
    send_request(REQ_SET_CUR, 8'h0, 7'd2, 8'd5);
    send_request(REQ_PUT, CH_TAB, 7'd0, 8'd0);
    send_request(REQ_PUT, CH_TAB, 7'd0, 8'd0);
    send_request(REQ_SET_CUR, 8'h0, 7'd2, 8'd9);
    send_request(REQ_PUT, 8'h5A, 7'd0, 8'd0);
    send_request(REQ_PUT, CH_NEWLINE, 7'd0, 8'd0);
    send_request(REQ_READ, 8'h0, 7'd1, 8'd9);
    wait_drained();
  endtask

  task automatic test_dimension_limits();
    // zero and oversize dimensions, cursor outside a shrunken screen
    write_register(CFG_COLS, 0);
    write_register(CFG_ROWS, 0);
    send_request(REQ_PUT, 8'h31, 7'd0, 8'd0);
    send_request(REQ_PUT, CH_TAB, 7'd0, 8'd0);
    send_request(REQ_READ, 8'h0, 7'd100, 8'd200);
    write_register(CFG_COLS, 511);
    write_register(CFG_ROWS, 255);
    send_request(REQ_SET_CUR, 8'h0, 7'd127, 8'd255);
    send_request(REQ_PUT, 8'h32, 7'd0, 8'd0);
    write_register(CFG_COLS, 256);
    write_register(CFG_ROWS, 2);
    send_request(REQ_PUT_HERE, 8'h33, 7'd0, 8'd0);
    send_request(REQ_READ, 8'h0, 7'd127, 8'd255);
    wait_drained();
  endtask

  task automatic random_batch(int count);
    logic [2:0] kind;
    logic [7:0] ch;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 40) kind = REQ_PUT;
      else if (pick < 55) kind = REQ_PUT_HERE;
      else if (pick < 70) kind = REQ_SET_CUR;
      else if (pick < 73) kind = REQ_CLEAR;
      else if (pick < 96) kind = REQ_READ;
      else kind = 3'($urandom_range(7, 5));
      pick = $urandom_range(99);
      if (pick < 10) ch = CH_NEWLINE;
      else if (pick < 16) ch = CH_TAB;
      else if (pick < 22) ch = CH_BACKSPACE;
      else if (pick < 26) ch = CH_RETURN;
      else if (pick < 80) ch = 8'($urandom_range(8'h7E, 8'h20));
      else ch = 8'($urandom);
      send_request(kind, ch, 7'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_random_traffic();
    int phase_idle [4] = '{0, 58, 0, 22};
    int phase_stall [4] = '{0, 0, 58, 22};
    int dims [4][2] = '{'{6, 4}, '{17, 3}, '{256, 2}, '{9, 128}};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      write_register(CFG_COLS, dims[p][0]);
      write_register(CFG_ROWS, dims[p][1]);
      write_register(CFG_FORE, $urandom_range(15));
      write_register(CFG_BACK, $urandom_range(15));
      random_batch(36);
      wait_drained();
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    req.valid = 1'b0;
    req.req_type = REQ_PUT;
    req.char_code = 8'h0;
    req.target_row = 7'h0;
    req.target_col = 8'h0;
    cfg.valid = 1'b0;
    cfg.index = CFG_COLS;
    cfg.data = 9'h0;
    cols_reg = 80;
    rows_reg = 25;
    fg_reg = 4'd7;
    bg_reg = 4'd0;
    cur_r = 0;
    cur_c = 0;
    foreach (screen[i]) screen[i] = {4'd0, 4'd7, CH_SPACE};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_screen();
    test_controls();
    test_small_screen();
    test_dimension_limits();
    test_random_traffic();
    wait_drained();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

// ===== text_console_cell_engine_top.f =====
design/tcce_pkg.sv
design/tcce_if.sv
design/tcce_cell_ram.sv
design/text_console_cell_engine_top.sv
design/tcce_checker.sv
bench/text_console_cell_engine_top_test.sv
